>>> rtl/boundary_tag_heap_allocator_core_defines.svh
// ---------------------------------------------------------------------------
// Boundary-tag heap allocator: assertion macros
// Shared concurrent check macros, clocked on clk and held off during rst.
// ---------------------------------------------------------------------------
`ifndef BOUNDARY_TAG_HEAP_ALLOCATOR_CORE_DEFINES_SVH
`define BOUNDARY_TAG_HEAP_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BTHAC_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define BTHAC_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/bthac_pkg.sv
// ---------------------------------------------------------------------------
// Boundary-tag heap allocator package
// Heap geometry, command kinds, queue entry and sequencer state types.
// ---------------------------------------------------------------------------
`default_nettype none

package bthac_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 24;
  localparam int FOOTER_BYTES = 16;
  localparam int OVERHEAD     = HEADER_BYTES + FOOTER_BYTES;
  localparam int CAPACITY     = HEAP_BYTES - OVERHEAD;
  localparam int ADDR_W       = 16;
  localparam int POS_W        = 18;
  localparam int TAG_W        = 17;
  localparam int Q_DEPTH      = 2;
  localparam int Q_PTR_W      = 1;
  localparam int Q_CNT_W      = 2;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_REJECT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] val;
  } q_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_SPLIT,
    ST_NEXT_EVAL,
    ST_MERGE,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

>>> rtl/bthac_front.sv
// ---------------------------------------------------------------------------
// Allocator front end
// Accept command items and classify them as allocate, free or reject.
// ---------------------------------------------------------------------------
`default_nettype none

module bthac_front (
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // req_size[16:0], addr[32:17], zero
  input  wire logic              s_axis_tuser,  // cmd
  input  wire logic              q_full,
  output logic                   q_push,
  output bthac_pkg::q_entry_t    q_entry
);

  logic [16:0] req_size;
  logic [15:0] addr;

  assign req_size      = s_axis_tdata[16:0];
  assign addr          = s_axis_tdata[32:17];
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_entry.kind = bthac_pkg::K_REJECT;
    q_entry.val  = '0;
    if (!s_axis_tuser) begin
      if (req_size != '0 && req_size <= 17'(bthac_pkg::CAPACITY)) begin
        q_entry.kind = bthac_pkg::K_ALLOC;
        q_entry.val  = req_size[15:0];
      end
    end else if (addr >= 16'(bthac_pkg::HEADER_BYTES)) begin
      q_entry.kind = bthac_pkg::K_FREE;
      q_entry.val  = addr - 16'(bthac_pkg::HEADER_BYTES);
    end
  end

endmodule

`default_nettype wire

>>> rtl/bthac_fifo.sv
// ---------------------------------------------------------------------------
// Command queue
// Short queue between the classifying front end and the tag walker.
// ---------------------------------------------------------------------------
`default_nettype none
`include "boundary_tag_heap_allocator_core_defines.svh"

module bthac_fifo (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire bthac_pkg::q_entry_t push_data,
  input  wire logic                pop,
  output bthac_pkg::q_entry_t      pop_data,
  output logic                     full,
  output logic                     not_empty
);

  bthac_pkg::q_entry_t                 entries [bthac_pkg::Q_DEPTH];
  logic [bthac_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [bthac_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [bthac_pkg::Q_CNT_W-1:0]       count;

  assign full      = count == bthac_pkg::Q_CNT_W'(bthac_pkg::Q_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + bthac_pkg::Q_CNT_W'(push) - bthac_pkg::Q_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  `BTHAC_ASSERT_NOW(a_no_pop_empty, pop, not_empty, "queue popped while empty")
  `BTHAC_ASSERT_NOW(a_no_push_full, push, !full || pop, "queue pushed while full")

endmodule

`default_nettype wire

>>> rtl/bthac_back.sv
// ---------------------------------------------------------------------------
// Tag walker
// Walk block headers in tag memory, carry out allocates and frees, and hold
// the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "boundary_tag_heap_allocator_core_defines.svh"

module bthac_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                q_valid,
  input  wire bthac_pkg::q_entry_t q_data,
  output logic                     q_pop,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata   // addr_out[15:0], ok[16], zero
);

  localparam int AW = bthac_pkg::ADDR_W;
  localparam int PW = bthac_pkg::POS_W;
  localparam int TW = bthac_pkg::TAG_W;

  bthac_pkg::state_t state, state_next;

  logic [TW-1:0]  tag_mem [bthac_pkg::HEAP_BYTES];
  logic [TW-1:0]  mem_q;
  logic [TW-1:0]  tag0;
  logic           rd_zero;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [TW-1:0]  mem_wd;

  bthac_pkg::kind_t kind;
  logic [AW-1:0]  val;
  logic [PW-1:0]  pos;
  logic [AW-1:0]  best, best_size;
  logic           have_best;
  logic [AW-1:0]  prev, left_size;
  logic           left_free, have_prev;
  logic [AW-1:0]  cur_size, n_size;
  logic           n_free;
  logic [AW-1:0]  res_addr;
  logic           res_ok;
  logic           out_valid;
  logic [AW-1:0]  out_addr;
  logic           out_ok;

  logic [TW-1:0]  rtag;
  logic [AW-1:0]  t_size;
  logic           t_free;
  logic [PW-1:0]  pos_step;
  logic           walk_end, fits, splittable, hit;
  logic [AW-1:0]  split_addr, split_size;
  logic [AW-1:0]  m_start, m_low, m_size;

  assign rtag       = rd_zero ? tag0 : mem_q;
  assign t_size     = rtag[AW-1:0];
  assign t_free     = rtag[TW-1];
  assign pos_step   = pos + PW'(bthac_pkg::OVERHEAD) + PW'(t_size);
  assign walk_end   = pos >= PW'(bthac_pkg::HEAP_BYTES)
                      || (kind == bthac_pkg::K_FREE && pos > PW'(val));
  assign fits       = t_free && t_size >= val;
  assign splittable = PW'(t_size) >= PW'(val) + PW'(bthac_pkg::OVERHEAD + 1);
  assign hit        = pos == PW'(val);
  assign split_addr = best + AW'(bthac_pkg::OVERHEAD) + val;
  assign split_size = best_size - val - AW'(bthac_pkg::OVERHEAD);
  assign m_start    = (have_prev && left_free) ? prev : val;
  assign m_low      = (have_prev && left_free)
                      ? left_size + AW'(bthac_pkg::OVERHEAD) + cur_size : cur_size;
  assign m_size     = n_free ? m_low + AW'(bthac_pkg::OVERHEAD) + n_size : m_low;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'b0, out_ok, out_addr};

  always_comb begin
    state_next = state;
    unique case (state)
      bthac_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_data.kind == bthac_pkg::K_REJECT)
                       ? bthac_pkg::ST_DONE : bthac_pkg::ST_READ;
        end
      end
      bthac_pkg::ST_READ: begin
        if (!walk_end) begin
          state_next = bthac_pkg::ST_EVAL;
        end else if (kind == bthac_pkg::K_ALLOC && have_best) begin
          state_next = bthac_pkg::ST_SPLIT;
        end else begin
          state_next = bthac_pkg::ST_DONE;
        end
      end
      bthac_pkg::ST_EVAL: begin
        if (kind == bthac_pkg::K_ALLOC) begin
          state_next = (fits && !splittable) ? bthac_pkg::ST_DONE : bthac_pkg::ST_READ;
        end else if (!hit) begin
          state_next = bthac_pkg::ST_READ;
        end else if (t_free) begin
          state_next = bthac_pkg::ST_DONE;
        end else if (pos_step < PW'(bthac_pkg::HEAP_BYTES)) begin
          state_next = bthac_pkg::ST_NEXT_EVAL;
        end else begin
          state_next = bthac_pkg::ST_MERGE;
        end
      end
      bthac_pkg::ST_NEXT_EVAL: state_next = bthac_pkg::ST_MERGE;
      bthac_pkg::ST_SPLIT:     state_next = bthac_pkg::ST_DONE;
      bthac_pkg::ST_MERGE:     state_next = bthac_pkg::ST_DONE;
      bthac_pkg::ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          state_next = bthac_pkg::ST_IDLE;
        end
      end
      default: state_next = bthac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    mem_addr = pos[AW-1:0];
    mem_wd   = '0;
    unique case (state)
      bthac_pkg::ST_IDLE: q_pop = q_valid;
      bthac_pkg::ST_READ: begin
        if (walk_end && kind == bthac_pkg::K_ALLOC && have_best) begin
          mem_we   = 1'b1;
          mem_addr = best;
          mem_wd   = {1'b0, val};
        end
      end
      bthac_pkg::ST_EVAL: begin
        if (kind == bthac_pkg::K_ALLOC && fits && !splittable) begin
          mem_we = 1'b1;
          mem_wd = {1'b0, t_size};
        end else begin
          mem_addr = pos_step[AW-1:0];
        end
      end
      bthac_pkg::ST_SPLIT: begin
        mem_we   = 1'b1;
        mem_addr = split_addr;
        mem_wd   = {1'b1, split_size};
      end
      bthac_pkg::ST_MERGE: begin
        mem_we   = 1'b1;
        mem_addr = m_start;
        mem_wd   = {1'b1, m_size};
      end
      bthac_pkg::ST_NEXT_EVAL, bthac_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[mem_addr] <= mem_wd;
    end
    mem_q <= tag_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bthac_pkg::ST_IDLE;
      out_valid <= 1'b0;
      tag0      <= {1'b1, AW'(bthac_pkg::CAPACITY)};
    end else begin
      state <= state_next;
      if (mem_we && mem_addr == '0) begin
        tag0 <= mem_wd;
      end
      if (state == bthac_pkg::ST_DONE && (!out_valid || m_axis_tready)) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_zero <= mem_addr == '0;
    if (state == bthac_pkg::ST_DONE && (!out_valid || m_axis_tready)) begin
      out_addr <= res_addr;
      out_ok   <= res_ok;
    end
    unique case (state)
      bthac_pkg::ST_IDLE: begin
        kind      <= q_data.kind;
        val       <= q_data.val;
        pos       <= '0;
        have_best <= 1'b0;
        have_prev <= 1'b0;
        n_free    <= 1'b0;
        res_ok    <= 1'b0;
        res_addr  <= '0;
      end
      bthac_pkg::ST_READ: begin
        if (walk_end && kind == bthac_pkg::K_ALLOC && have_best) begin
          res_ok   <= 1'b1;
          res_addr <= best + AW'(bthac_pkg::HEADER_BYTES);
        end
      end
      bthac_pkg::ST_EVAL: begin
        pos <= pos_step;
        if (kind == bthac_pkg::K_ALLOC) begin
          if (fits && splittable) begin
            if (!have_best || t_size < best_size) begin
              have_best <= 1'b1;
              best      <= pos[AW-1:0];
              best_size <= t_size;
            end
          end else if (fits) begin
            res_ok   <= 1'b1;
            res_addr <= pos[AW-1:0] + AW'(bthac_pkg::HEADER_BYTES);
          end
        end else if (hit) begin
          cur_size <= t_size;
        end else begin
          have_prev <= 1'b1;
          prev      <= pos[AW-1:0];
          left_size <= t_size;
          left_free <= t_free;
        end
      end
      bthac_pkg::ST_NEXT_EVAL: begin
        n_free <= t_free;
        n_size <= t_size;
      end
      bthac_pkg::ST_MERGE: res_ok <= 1'b1;
      bthac_pkg::ST_SPLIT, bthac_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  `BTHAC_ASSERT_NOW(a_we_in_work, mem_we,
    !(state == bthac_pkg::ST_IDLE) && !(state == bthac_pkg::ST_DONE),
    "tag write outside a write state")
  `BTHAC_ASSERT_NEXT(a_done_loads, state == bthac_pkg::ST_DONE && !out_valid,
    out_valid, "result not loaded into output register")
  `BTHAC_ASSERT_NOW(a_pop_idle, q_pop,
    state == bthac_pkg::ST_IDLE && q_valid, "queue popped while busy")

endmodule

`default_nettype wire

>>> rtl/boundary_tag_heap_allocator_core.sv
// ---------------------------------------------------------------------------
// Boundary-tag heap allocator core
// Allocate and free blocks of a 64 KiB heap kept as header tags in memory.
// ---------------------------------------------------------------------------
// One result per command. The walker pops a command in its idle state; a rejected
// command then goes to the done state to load its result. An allocate walks the
// block headers in address order, a read and an evaluate state per block (one tag
// memory read port), until a block is taken whole, or to the end of the heap and
// then writes the taken and split headers and loads the result; a free walks
// headers up to its target, then reads the next one, merges and loads the result.
// The command queue holds two items, so commands are taken while the walker
// is busy and a result waits in its output register.
`default_nettype none

module boundary_tag_heap_allocator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // req_size[16:0], addr[32:17], zero
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // addr_out[15:0], ok[16], zero
);

  bthac_pkg::q_entry_t push_entry, pop_entry;
  logic q_full, q_push, q_pop, q_not_empty;

  bthac_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  bthac_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  bthac_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_not_empty),
    .q_data        (pop_entry),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire
